>>> hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bole_pkg.sv
// shared types and codes of the ordered list engine
`timescale 1ns / 1ps
`default_nettype none

package bole_pkg;

  localparam int ACT_W  = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int ST_W   = 2;

  localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_END   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INS_POS   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEL_END   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DEL_POS   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_TRAVERSE  = 3'd6;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic pending;
    logic trav;
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/bounded_ordered_list_engine.sv
// top level of the ordered list engine
//
// Command port: drive action, value and position with start high; the
// transfer takes place at a clock edge where start is high and busy is low.
// busy stays high until every result of that command has been shown.
// Results come out on element, status and last, each valid for exactly one
// cycle while strobe is high; the receiver cannot stall, so it must take
// every result in the cycle it appears.
// Insert and delete give one status result. With n elements to move (the
// ones behind the insert or delete point), those moves come first and the
// result is shown when the new length is committed. One element moves per
// cycle through the single read and single write port of the element
// memory. Traverse of a list of length n gives n results on consecutive
// cycles, with last on the final one; an empty list gives one status
// result. Errors leave the list unchanged.
// Reset empties the list and returns the controller to idle.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bounded_ordered_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [bole_pkg::ACT_W-1:0]          action,
  input  logic signed [bole_pkg::DATA_W-1:0]  value,
  input  logic [bole_pkg::POS_W-1:0]          position,
  output logic                                strobe,
  output logic signed [bole_pkg::DATA_W-1:0]  element,
  output logic [bole_pkg::ST_W-1:0]           status,
  output logic                                last
);
  import bole_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bole_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bole_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .action   (action),
    .value    (value),
    .position (position),
    .strobe   (strobe),
    .element  (element),
    .status   (status),
    .last     (last)
  );

  `CHK_NEXT(a_accept_busy, start && !busy, busy, "command transfer did not raise busy")
  `CHK_SAME(a_strobe_busy, strobe, busy, "result shown while idle")
  `CHK_NEXT(a_last_gap, strobe && last, !strobe, "result after the final one")
  `CHK_SAME(a_commit_drain, cmd.commit, !sts.pending, "commit while a shift is in flight")

endmodule

`default_nettype wire

>>> hdl/bole_ctrl.sv
// controller state machine of the ordered list engine
`timescale 1ns / 1ps
`default_nettype none

module bole_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bole_pkg::sts_t  sts,
  output bole_pkg::cmd_t  cmd,
  output logic            busy
);
  import bole_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.step = sts.more;
        if (!sts.more && !sts.pending) begin
          state_next = sts.trav ? S_IDLE : S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

>>> hdl/bole_dp.sv
// datapath of the ordered list engine: element memory, count and walk pointer
`timescale 1ns / 1ps
`default_nettype none

module bole_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bole_pkg::cmd_t                      cmd,
  output bole_pkg::sts_t                      sts,
  input  logic [bole_pkg::ACT_W-1:0]          action,
  input  logic signed [bole_pkg::DATA_W-1:0]  value,
  input  logic [bole_pkg::POS_W-1:0]          position,
  output logic                                strobe,
  output logic signed [bole_pkg::DATA_W-1:0]  element,
  output logic [bole_pkg::ST_W-1:0]           status,
  output logic                                last
);
  import bole_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] val;

  logic [CW-1:0]   count;
  logic [CW-1:0]   rem;
  logic [AW-1:0]   rp;
  logic [AW-1:0]   pe;
  logic [AW-1:0]   rd_a;
  logic            rd_v;
  logic            rd_last;
  logic [ST_W-1:0] st;
  logic            ins_op;
  logic            del_op;
  logic            trav_op;

  logic [ST_W-1:0] st_next;
  logic            ins_next;
  logic            del_next;
  logic            trav_next;
  logic [CW-1:0]   pe_next;
  logic [CW-1:0]   rem_next;
  logic [AW-1:0]   rp_next;
  logic [CW-1:0]   pos_c;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  // decode of the request against the current length
  always_comb begin
    st_next   = ST_OK;
    ins_next  = 1'b0;
    del_next  = 1'b0;
    trav_next = 1'b0;
    pe_next   = '0;
    rem_next  = '0;
    rp_next   = '0;
    pos_c     = (32'(position) > 32'(count)) ? count : CW'(position);
    case (action)
      ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS: begin
        if (count == CW'(CAPACITY)) begin
          st_next = ST_FULL;
        end else begin
          ins_next = 1'b1;
          if (action == ACT_INS_FRONT) begin
            pe_next = '0;
          end else if (action == ACT_INS_END) begin
            pe_next = count;
          end else begin
            pe_next = pos_c;
          end
          rem_next = count - pe_next;
          rp_next  = AW'(count - CW'(1));
        end
      end
      ACT_DEL_FRONT, ACT_DEL_END, ACT_DEL_POS: begin
        if (count == '0) begin
          st_next = ST_EMPTY;
        end else if (action == ACT_DEL_POS && 32'(position) >= 32'(count)) begin
          st_next = ST_RANGE;
        end else begin
          del_next = 1'b1;
          if (action == ACT_DEL_FRONT) begin
            pe_next = '0;
          end else if (action == ACT_DEL_END) begin
            pe_next = count - CW'(1);
          end else begin
            pe_next = CW'(position);
          end
          rem_next = count - CW'(1) - pe_next;
          rp_next  = AW'(pe_next + CW'(1));
        end
      end
      ACT_TRAVERSE: begin
        if (count == '0) begin
          st_next = ST_EMPTY;
        end else begin
          trav_next = 1'b1;
          rem_next  = count;
          rp_next   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rem     <= '0;
      rd_v    <= 1'b0;
      ins_op  <= 1'b0;
      del_op  <= 1'b0;
      trav_op <= 1'b0;
    end else begin
      rd_v <= cmd.step;
      if (cmd.load) begin
        rem     <= rem_next;
        ins_op  <= ins_next;
        del_op  <= del_next;
        trav_op <= trav_next;
      end
      if (cmd.step) begin
        rem <= rem - CW'(1);
      end
      if (cmd.commit) begin
        if (ins_op) begin
          count <= count + CW'(1);
        end else if (del_op) begin
          count <= count - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st  <= st_next;
      pe  <= AW'(pe_next);
      rp  <= rp_next;
      val <= value;
    end
    if (cmd.step) begin
      rp      <= ins_op ? (rp - AW'(1)) : (rp + AW'(1));
      rd_a    <= rp;
      rd_last <= (rem == CW'(1));
    end
  end

  // shift writes move one element per cycle; for an insert the final write places the new value
  always_comb begin
    wr_en   = (rd_v && (ins_op || del_op)) || (cmd.commit && ins_op);
    wr_addr = pe;
    wr_data = val;
    if (rd_v) begin
      wr_addr = ins_op ? (rd_a + AW'(1)) : (rd_a - AW'(1));
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.step) begin
      rd_data <= mem[rp];
    end
  end

  assign sts.more    = (rem != '0);
  assign sts.pending = rd_v;
  assign sts.trav    = trav_op;

  assign strobe  = (rd_v && trav_op) || cmd.commit;
  assign element = (rd_v && trav_op) ? rd_data : '0;
  assign status  = cmd.commit ? st : ST_OK;
  assign last    = cmd.commit || (rd_v && trav_op && rd_last);

endmodule

`default_nettype wire

>>> test/testbench.sv
// self-checking testbench for the ordered list engine, with a scoreboard class
`timescale 1ns / 1ps

module testbench;
  import bole_pkg::*;

  localparam int CAPACITY = 16;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [ACT_W-1:0] action = ACT_TRAVERSE;
  logic signed [DATA_W-1:0] value = '0;
  logic [POS_W-1:0] position = '0;
  logic strobe;
  logic signed [DATA_W-1:0] element;
  logic [ST_W-1:0] status;
  logic last;
  bit quiet = 1'b0;

  typedef struct {
    logic signed [DATA_W-1:0] element;
    logic [ST_W-1:0] status;
    logic last;
  } list_result_t;

  class list_tracker;
    logic signed [DATA_W-1:0] contents[$];
    list_result_t pending_results[$];
    int capacity;
    int errors, commands, checked, traversals, full_hits, empty_hits, range_hits;

    function new(int cap);
      capacity = cap;
    endfunction

    function void push(logic signed [DATA_W-1:0] e, logic [ST_W-1:0] s, logic l);
      list_result_t r;
      r.element = e;
      r.status = s;
      r.last = l;
      pending_results.push_back(r);
    endfunction

    // accepted transfer: update the shadow list and queue what it should emit
    function void note_command(logic [ACT_W-1:0] act, logic signed [DATA_W-1:0] val,
                               logic [POS_W-1:0] pos);
      int n;
      int at;
      logic [ST_W-1:0] st;
      n = contents.size();
      st = ST_OK;
      commands++;
      case (act)
        ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS: begin
          if (n >= capacity) begin
            st = ST_FULL;
          end else begin
            if (act == ACT_INS_FRONT) at = 0;
            else if (act == ACT_INS_END) at = n;
            else at = (int'(pos) > n) ? n : int'(pos);
            contents.insert(at, val);
          end
        end
        ACT_DEL_FRONT, ACT_DEL_END, ACT_DEL_POS: begin
          if (act == ACT_DEL_FRONT) at = 0;
          else if (act == ACT_DEL_END) at = n - 1;
          else at = int'(pos);
          if (n == 0) st = ST_EMPTY;
          else if (at >= n) st = ST_RANGE;
          else contents.delete(at);
        end
        ACT_TRAVERSE: begin
          traversals++;
          if (n == 0) begin
            st = ST_EMPTY;
          end else begin
            foreach (contents[i]) push(contents[i], ST_OK, i == n - 1);
            return;
          end
        end
        default: ;
      endcase
      if (st == ST_FULL) full_hits++;
      if (st == ST_EMPTY) empty_hits++;
      if (st == ST_RANGE) range_hits++;
      push('0, st, 1'b1);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] e, logic [ST_W-1:0] s, logic l);
      list_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: element %0d status %0d last %0b", e, s, l);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (e !== want.element) begin
        $error("element mismatch: expected %0d, got %0d", want.element, e);
        errors++;
      end
      if (s !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, s);
        errors++;
      end
      if (l !== want.last) begin
        $error("last mismatch: expected %0b, got %0b", want.last, l);
        errors++;
      end
    endfunction
  endclass

  list_tracker tracker = new(CAPACITY);

  bounded_ordered_list_engine #(.CAPACITY(CAPACITY)) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .value(value),
    .position(position),
    .strobe(strobe),
    .element(element),
    .status(status),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && strobe) tracker.check_result(element, status, last);
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_command(input logic [ACT_W-1:0] act,
                               input logic signed [DATA_W-1:0] val,
                               input logic [POS_W-1:0] pos);
    while (!quiet && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    value <= val;
    position <= pos;
    do @(posedge clk); while (busy);
    tracker.note_command(act, val, pos);
  endtask

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int mode;
    int r;
    logic [ACT_W-1:0] act;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty list cases
    issue_command(ACT_TRAVERSE, 0, 0);
    issue_command(ACT_DEL_FRONT, 0, 0);
    issue_command(ACT_DEL_END, 0, 0);
    issue_command(ACT_DEL_POS, 0, 0);
    // extremes, append past the length, interior insert
    issue_command(ACT_INS_FRONT, 32'sh80000000, 0);
    issue_command(ACT_INS_END, 32'sh7fffffff, 0);
    issue_command(ACT_INS_POS, -1, 16);
    issue_command(ACT_INS_POS, 0, 1);
    issue_command(ACT_TRAVERSE, 0, 0);
    issue_command(ACT_DEL_POS, 0, 4);
    issue_command(ACT_DEL_POS, 0, 2);
    issue_command(ACT_UNUSED, 32'sh5a5a5a5a, 31);
    // fill up, then hit the full list
    while (tracker.contents.size() < CAPACITY)
      issue_command(ACT_INS_POS, pick_value(), POS_W'($urandom_range(0, 16)));
    issue_command(ACT_INS_FRONT, 1, 0);
    issue_command(ACT_INS_END, 2, 0);
    issue_command(ACT_INS_POS, 3, 5);
    issue_command(ACT_TRAVERSE, 0, 0);
    issue_command(ACT_DEL_POS, 0, 16);
    issue_command(ACT_DEL_POS, 0, 15);
    issue_command(ACT_DEL_END, 0, 0);
    issue_command(ACT_DEL_FRONT, 0, 0);
    issue_command(ACT_TRAVERSE, 0, 0);

    // random phases that grow, shrink or mix the list
    mode = 0;
    for (int k = 0; k < 400; k++) begin
      if (k % 25 == 0) mode = $urandom_range(0, 2);
      quiet = (k >= 150 && k < 230);
      r = $urandom_range(0, 99);
      case (mode)
        0: begin
          if (r < 60) act = ACT_INS_FRONT + ACT_W'($urandom_range(0, 2));
          else if (r < 82) act = ACT_DEL_FRONT + ACT_W'($urandom_range(0, 2));
          else act = ACT_TRAVERSE;
        end
        1: begin
          if (r < 25) act = ACT_INS_FRONT + ACT_W'($urandom_range(0, 2));
          else if (r < 82) act = ACT_DEL_FRONT + ACT_W'($urandom_range(0, 2));
          else act = ACT_TRAVERSE;
        end
        default: act = ACT_W'($urandom_range(0, 6));
      endcase
      issue_command(act, pick_value(), POS_W'($urandom_range(0, 16)));
    end
    start <= 1'b0;
    quiet = 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    if (tracker.pending_results.size() != 0)
      $error("%0d results never arrived", tracker.pending_results.size());
    $display("covered %0d commands, %0d results checked, %0d traversals",
             tracker.commands, tracker.checked, tracker.traversals);
    $display("rejections seen: %0d full, %0d empty, %0d out of range",
             tracker.full_hits, tracker.empty_hits, tracker.range_hits);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/bole_pkg.sv
hdl/bole_ctrl.sv
hdl/bole_dp.sv
hdl/bounded_ordered_list_engine.sv
test/testbench.sv
